// ===== design/rcfp_pkg.sv =====
// Shared types and constants of the remote control frame parser.
package rcfp_pkg;

    // Frame header bytes.
    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h55;

    // Only buffer bytes 0 to 18 are ever read back, so only those are stored.
    localparam int CAPTURE_TAPS = 19;

    // Reset value of the lock word: the all-lock byte starts at one.
    localparam logic [31:0] LOCK_RESET = 32'h0100_0000;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_CSUM_BAD = 3'd2,
        ST_LEN_BAD  = 3'd3,
        ST_HDR_ERR  = 3'd4
    } status_t;

    typedef struct packed {
        status_t status;
        logic    store;      // write the byte into the frame buffer
        logic    capture;    // good frame: load the command registers
        logic    clear_cmd;  // header error: zero motion and aux commands
    } step_ctrl_t;

endpackage

// ===== design/rcfp_frame_check.sv =====
// Per-byte frame decision: buffer overflow, header, length, end of frame and checksum checks.
module rcfp_frame_check #(
    parameter int MAX_PAYLOAD = 16,
    localparam int CntW = $clog2(MAX_PAYLOAD + 9)
) (
    input  logic [7:0]             rx_byte,
    input  logic [CntW-1:0]        byte_count,
    input  logic [7:0]             head0,
    input  logic [7:0]             head1,
    input  logic [7:0]             len,
    input  logic [7:0]             running_sum,
    output rcfp_pkg::step_ctrl_t   ctrl,
    output logic [CntW-1:0]        count_next,
    output logic [7:0]             sum_next
);
    import rcfp_pkg::*;

    localparam int BufDepth = MAX_PAYLOAD + 8;
    localparam int LenMax   = MAX_PAYLOAD + 4;

    logic [CntW-1:0] count_inc;
    logic [7:0]      first_byte;
    logic [8:0]      frame_end;
    logic            restart;

    assign count_inc = byte_count + CntW'(1);
    // The first byte of a frame is checked in the cycle it arrives.
    assign first_byte = (byte_count == '0) ? rx_byte : head0;
    assign frame_end  = {1'b0, len} + 9'd4;

    always_comb begin
        ctrl.status    = ST_BUSY;
        ctrl.store     = 1'b0;
        ctrl.capture   = 1'b0;
        ctrl.clear_cmd = 1'b0;
        restart        = 1'b0;
        priority if (byte_count >= CntW'(BufDepth)) begin
            ctrl.status    = ST_HDR_ERR;
            ctrl.clear_cmd = 1'b1;
            restart        = 1'b1;
        end else begin
            ctrl.store = 1'b1;
            priority if (first_byte != SYNC0) begin
                ctrl.status    = ST_HDR_ERR;
                ctrl.clear_cmd = 1'b1;
                restart        = 1'b1;
            end else if (count_inc > CntW'(3)) begin
                priority if (head1 != SYNC1) begin
                    ctrl.status    = ST_HDR_ERR;
                    ctrl.clear_cmd = 1'b1;
                    restart        = 1'b1;
                end else if (len > 8'(LenMax)) begin
                    ctrl.status = ST_LEN_BAD;
                    restart     = 1'b1;
                end else if (9'(count_inc) >= frame_end) begin
                    if (running_sum == rx_byte) begin
                        ctrl.status  = ST_ACCEPT;
                        ctrl.capture = 1'b1;
                    end else begin
                        ctrl.status = ST_CSUM_BAD;
                    end
                    restart = 1'b1;
                end else begin
                    // Payload byte: keep counting and summing.
                    restart = 1'b0;
                end
            end else begin
                // First, second or third byte of the header is still being collected.
                restart = 1'b0;
            end
        end
    end

    assign count_next = restart ? '0 : count_inc;
    assign sum_next   = restart ? 8'd0 : running_sum + rx_byte;

endmodule

// ===== design/remote_control_frame_parser.sv =====
// Top level of the remote control frame parser.
//
// Each input transfer on s_* carries one received byte of the stream
// (s_rx_byte). Every byte gives exactly one result transfer on m_*: a status
// code (busy, frame accepted, checksum bad, length too large, header error)
// together with the accepted-frame count and the motion, aux and lock command
// words as they stand after that byte.
//
// The result of a byte is registered and shows in the cycle after the byte
// is taken. Throughput is one byte per cycle; the whole check runs between
// the frame state registers and the result register. s_ready is high while
// the result register is empty or is being emptied in the same cycle, so a
// stall on m_ready holds the result and stops input until it is taken.
//
// A synchronous reset (aresetn low) clears the frame buffer, the byte count,
// the running sum, the frame count and the command words; the all-lock byte
// of the lock word resets to one. No result is pending after reset.
module remote_control_frame_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_frames_accepted,
    output logic [31:0] m_motion_bytes,
    output logic [39:0] m_aux_bytes,
    output logic [31:0] m_lock_bytes
);
    import rcfp_pkg::*;

    localparam int CntW = $clog2(MAX_PAYLOAD + 9);

    logic [7:0]      buf_reg [CAPTURE_TAPS];
    logic [7:0]      tap     [CAPTURE_TAPS];
    logic [CntW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]      sum_reg, sum_next;
    logic [31:0]     frames_reg, frames_next;
    logic [31:0]     motion_reg, motion_next;
    logic [39:0]     aux_reg, aux_next;
    logic [31:0]     lock_reg, lock_next;
    status_t         status_reg;
    logic            m_valid_reg, m_valid_next;
    logic            accept;
    step_ctrl_t      ctrl;
    logic [CntW-1:0] count_step;
    logic [7:0]      sum_step;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rcfp_frame_check #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_check (
        .rx_byte     (s_rx_byte),
        .byte_count  (byte_count_reg),
        .head0       (buf_reg[0]),
        .head1       (buf_reg[1]),
        .len         (buf_reg[2]),
        .running_sum (sum_reg),
        .ctrl        (ctrl),
        .count_next  (count_step),
        .sum_next    (sum_step)
    );

    // The byte being written is visible to the command capture at once.
    always_comb begin
        for (int i = 0; i < CAPTURE_TAPS; i++) begin
            tap[i] = (ctrl.store && byte_count_reg == CntW'(i)) ? s_rx_byte : buf_reg[i];
        end
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        frames_next     = frames_reg;
        motion_next     = motion_reg;
        aux_next        = aux_reg;
        lock_next       = lock_reg;
        if (accept) begin
            byte_count_next = count_step;
            sum_next        = sum_step;
            if (ctrl.capture) begin
                frames_next = frames_reg + 32'd1;
                lock_next   = {tap[18], tap[14], tap[4], tap[3]};
                motion_next = {tap[8], tap[7], tap[6], tap[5]};
                aux_next    = {tap[13], tap[12], tap[11], tap[10], tap[9]};
            end else if (ctrl.clear_cmd) begin
                motion_next = '0;
                aux_next    = '0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CAPTURE_TAPS; i++) begin
                buf_reg[i] <= 8'd0;
            end
            byte_count_reg <= '0;
            sum_reg        <= 8'd0;
            frames_reg     <= 32'd0;
            motion_reg     <= 32'd0;
            aux_reg        <= 40'd0;
            lock_reg       <= LOCK_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            for (int i = 0; i < CAPTURE_TAPS; i++) begin
                if (accept && ctrl.store && byte_count_reg == CntW'(i)) begin
                    buf_reg[i] <= s_rx_byte;
                end
            end
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            frames_reg     <= frames_next;
            motion_reg     <= motion_next;
            aux_reg        <= aux_next;
            lock_reg       <= lock_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= ctrl.status;
        end
    end

    // State changes only on an input transfer, which also loads the result
    // register, so the state registers always match the pending result.
    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_frames_accepted = frames_reg;
    assign m_motion_bytes    = motion_reg;
    assign m_aux_bytes       = aux_reg;
    assign m_lock_bytes      = lock_reg;

endmodule

// ===== design/rcfp_checker.sv =====
// Port-level checks of the remote control frame parser and their binding.
module rcfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_frames_accepted,
    input logic [31:0] m_motion_bytes,
    input logic [39:0] m_aux_bytes,
    input logic [31:0] m_lock_bytes
);
    import rcfp_pkg::*;

    // A stalled result keeps its status and frame count.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_frames_accepted))
        else $error("result changed while stalled");

    // The frame count steps by one exactly when a frame is accepted.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=>
            ((m_status == ST_ACCEPT) == (m_frames_accepted == 32'($past(m_frames_accepted) + 1))))
        else $error("frame count does not follow accepted frames");

    // A header error leaves the motion and aux commands at zero.
    a_hdr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=>
            (m_status != ST_HDR_ERR || (m_motion_bytes == 32'd0 && m_aux_bytes == 40'd0)))
        else $error("header error did not clear the commands");

    // Without a transfer the parser state does not move.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(aresetn) |->
            $stable(m_frames_accepted) && $stable(m_lock_bytes) && $stable(m_motion_bytes))
        else $error("state changed without a transfer");

endmodule

bind remote_control_frame_parser rcfp_checker u_rcfp_checker (.*);
